[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is low
`define BAL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bal assertion failed");

// same, with a caller message
`define BAL_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

[src/bal_pkg.sv]
package bal_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W_DEF   = 32;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_NOP    = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } bal_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] data_out;
    logic             status;
    logic             last;
  } bal_out_t;

  typedef struct packed {
    cmd_e             kind;
    logic             at_back;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } bal_cmd_t;

endpackage

[src/bal_stream_if.sv]
interface bal_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/bal_front.sv]
module bal_front (
  input  logic        clk_i,
  input  logic        rst_ni,
  bal_stream_if.sink   in_if,
  bal_stream_if.source cmd_if
);
  import bal_pkg::*;

  logic     valid_q;
  bal_cmd_t cmd_q, cmd_d;
  logic     take;

  assign in_if.ready = !valid_q || cmd_if.ready;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    cmd_d.kind    = CMD_NOP;
    cmd_d.at_back = 1'b0;
    cmd_d.index   = in_if.data.index;
    cmd_d.count   = in_if.data.count;
    cmd_d.value   = in_if.data.value;
    if (in_if.data.count != '0) begin
      case (op_e'(in_if.data.op))
        OP_PUSH: begin
          cmd_d.kind    = CMD_INSERT;
          cmd_d.at_back = 1'b1;
        end
        OP_POP: begin
          cmd_d.kind    = CMD_REMOVE;
          cmd_d.at_back = 1'b1;
        end
        OP_INSERT: cmd_d.kind = CMD_INSERT;
        OP_REMOVE: cmd_d.kind = CMD_REMOVE;
        default:   cmd_d.kind = CMD_NOP;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_if.ready) begin
      valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_if.valid = valid_q;
  assign cmd_if.data  = cmd_q;
endmodule

[src/bal_queue.sv]
`include "assert_macros.svh"

module bal_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  bal_stream_if.sink   wr_if,
  bal_stream_if.source rd_if
);
  import bal_pkg::*;

  bal_cmd_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign wr_if.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign rd_if.valid = (cnt_q != '0);
  assign rd_if.data  = mem_q[rd_q];
  assign push        = wr_if.valid && wr_if.ready;
  assign pop         = rd_if.valid && rd_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= wr_if.data;
    end
  end

  `BAL_ASSERT(a_q_cnt_bound, clk_i, rst_ni, cnt_q <= QCNT_W'(QUEUE_DEPTH))
  `BAL_ASSERT_MSG(a_q_ptr_gap, clk_i, rst_ni, (cnt_q == '0) |-> (wr_q == rd_q), "queue ptr skew")
  `BAL_ASSERT(a_q_hold, clk_i, rst_ni, (rd_if.valid && !rd_if.ready) |=> rd_if.valid)
endmodule

[src/bal_back.sv]
`include "assert_macros.svh"

module bal_back #(
  parameter int unsigned CAPACITY = bal_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_W   = bal_pkg::DATA_W_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bal_pkg::LIMIT_W-1:0] cfg_wdata_i,
  bal_stream_if.sink                  cmd_if,
  bal_stream_if.source                out_if
);
  import bal_pkg::*;

  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;

  logic [DATA_W-1:0]  cells_q [CAPACITY];
  logic [DATA_W-1:0]  dn_data [CAPACITY];
  logic [DATA_W-1:0]  up_data [CAPACITY];
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LIMIT_W-1:0] limit_q;
  state_e             state_q, state_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic               out_valid_q;
  bal_out_t           out_q, out_d;

  logic              emit, step_ok, cmd_ready, ins_en, rem_en;
  logic [POS_W-1:0]  op_pos, ins_pos, rm_start;
  logic [DATA_W-1:0] rd_data;
  logic [CMP_W-1:0]  len_x, idx_x, cnt_x, eff_lim;
  logic              ins_bad, rm_bad;

  assign len_x   = CMP_W'(len_q);
  assign idx_x   = CMP_W'(cmd_if.data.index);
  assign cnt_x   = CMP_W'(cmd_if.data.count);
  assign eff_lim = (CMP_W'(limit_q) < CMP_W'(CAPACITY)) ? CMP_W'(limit_q) : CMP_W'(CAPACITY);

  assign ins_bad = ((len_x + CMP_W'(1)) > eff_lim) || (!cmd_if.data.at_back && (idx_x > len_x));
  assign rm_bad  = cmd_if.data.at_back ? (cnt_x > len_x) : ((idx_x + cnt_x) > len_x);

  assign ins_pos  = cmd_if.data.at_back ? POS_W'(len_q) : POS_W'(cmd_if.data.index);
  assign rm_start = cmd_if.data.at_back ? POS_W'(len_x - cnt_x) : POS_W'(cmd_if.data.index);

  assign op_pos  = (state_q == ST_RUN) ? pos_q :
                   ((cmd_if.data.kind == CMD_INSERT) ? ins_pos : rm_start);
  assign rd_data = cells_q[op_pos];

  assign step_ok      = !out_valid_q || out_if.ready;
  assign cmd_if.ready = cmd_ready;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
    if (g < CAPACITY - 1) begin : g_dn
      assign dn_data[g] = cells_q[g + 1];
    end else begin : g_dn_end
      assign dn_data[g] = cells_q[g];
    end
    if (g > 0) begin : g_up
      assign up_data[g] = cells_q[g - 1];
    end else begin : g_up_end
      assign up_data[g] = cells_q[g];
    end
  end

  always_comb begin
    state_d          = state_q;
    len_d            = len_q;
    pos_d            = pos_q;
    rem_d            = rem_q;
    cmd_ready        = 1'b0;
    emit             = 1'b0;
    ins_en           = 1'b0;
    rem_en           = 1'b0;
    out_d.data_out   = '0;
    out_d.status     = STATUS_OK;
    out_d.last       = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (cmd_if.valid && step_ok) begin
          cmd_ready = 1'b1;
          emit      = 1'b1;
          case (cmd_if.data.kind)
            CMD_INSERT: begin
              if (ins_bad) begin
                out_d.status = STATUS_REJECT;
              end else begin
                ins_en = 1'b1;
                len_d  = len_q + LEN_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (rm_bad) begin
                out_d.status = STATUS_REJECT;
              end else begin
                rem_en         = 1'b1;
                len_d          = len_q - LEN_W'(1);
                out_d.data_out = OUT_W'(rd_data);
                if (cmd_if.data.count != CNT_W'(1)) begin
                  out_d.last = 1'b0;
                  state_d    = ST_RUN;
                  rem_d      = cmd_if.data.count - CNT_W'(1);
                  pos_d      = rm_start;
                end
              end
            end
            default: begin
              out_d.status = STATUS_OK;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (step_ok) begin
          emit           = 1'b1;
          rem_en         = 1'b1;
          len_d          = len_q - LEN_W'(1);
          out_d.data_out = OUT_W'(rd_data);
          out_d.last     = (rem_q == CNT_W'(1));
          rem_d          = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      limit_q     <= LIMIT_RST;
      pos_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (step_ok) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  // shift-capable cell row
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CAPACITY; k++) begin
      if (ins_en) begin
        if (POS_W'(k) == op_pos) begin
          cells_q[k] <= DATA_W'(cmd_if.data.value);
        end else if (POS_W'(k) > op_pos) begin
          cells_q[k] <= up_data[k];
        end
      end else if (rem_en && (POS_W'(k) >= op_pos)) begin
        cells_q[k] <= dn_data[k];
      end
    end
  end

  `BAL_ASSERT(a_len_cap, clk_i, rst_ni, len_q <= LEN_W'(CAPACITY))
  `BAL_ASSERT(a_run_rem, clk_i, rst_ni, (state_q == ST_RUN) |-> (rem_q != '0))
  `BAL_ASSERT(a_run_len, clk_i, rst_ni, (state_q == ST_RUN) |-> (CMP_W'(rem_q) <= len_x))
  `BAL_ASSERT_MSG(a_rem_dec, clk_i, rst_ni, rem_en |=> (len_q == $past(len_q) - LEN_W'(1)), "len step")
endmodule

[src/bounded_array_list.sv]
// Path: an input transfer reaches its first result through the front register,
// queue entry and output register, later while the back end drains an earlier run.
// Results: push, insert, zero count and rejected requests give one result each;
// pop or remove of n gives n results from the cell row, one per cycle unless stalled.
// Reset: length 0, limit 16, queue and output empty; entries undefined until written.
module bounded_array_list #(
  parameter int unsigned CAPACITY = bal_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_W   = bal_pkg::DATA_W_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bal_pkg::LIMIT_W-1:0] cfg_wdata_i,
  bal_stream_if.sink                  in_if,
  bal_stream_if.source                out_if
);
  import bal_pkg::*;

  bal_stream_if #(.T(bal_cmd_t)) fe_if ();
  bal_stream_if #(.T(bal_cmd_t)) be_if ();

  bal_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .cmd_if (fe_if)
  );

  bal_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_if  (fe_if),
    .rd_if  (be_if)
  );

  bal_back #(
    .CAPACITY (CAPACITY),
    .DATA_W   (DATA_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_if      (be_if),
    .out_if      (out_if)
  );
endmodule

[tb/sv/bal_checker.sv]
`timescale 1ns / 100ps

module bal_checker #(
  parameter int unsigned CAPACITY = bal_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bal_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  bal_pkg::bal_in_t            req_data_i,
  input  logic                        res_valid_i,
  input  logic                        res_ready_i,
  input  bal_pkg::bal_out_t           res_data_i,
  output int unsigned                 err_cnt_o,
  output int unsigned                 pending_o,
  output int unsigned                 list_len_o
);
  import bal_pkg::*;

  logic [OUT_W-1:0] cells [CAPACITY];
  int unsigned      list_len;
  logic [LIMIT_W-1:0] limit_reg;
  bal_out_t         pending_results [$];
  int unsigned      err_cnt;

  function automatic void expect_result(logic [OUT_W-1:0] data, logic status, logic last);
    bal_out_t r;
    r.data_out = data;
    r.status   = status;
    r.last     = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // hand out cells [start, start+n) in ascending order, then close the gap
  function automatic void take_run(int unsigned start, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      expect_result(cells[start + i], STATUS_OK, (i + 1 == n));
    end
    for (int unsigned i = start; i + n < list_len; i++) begin
      cells[i] = cells[i + n];
    end
    list_len -= n;
  endfunction

  function automatic void apply_request(bal_in_t req);
    int unsigned cap;
    int unsigned idx;
    int unsigned cnt;
    bit          rejected;
    cap      = (limit_reg < CAPACITY) ? limit_reg : CAPACITY;
    idx      = req.index;
    cnt      = req.count;
    rejected = 1'b0;
    if (cnt == 0) begin
      expect_result('0, STATUS_OK, 1'b1);
    end else begin
      case (op_e'(req.op))
        OP_PUSH: begin
          if (list_len + 1 > cap) begin
            rejected = 1'b1;
          end else begin
            cells[list_len] = req.value;
            list_len++;
            expect_result('0, STATUS_OK, 1'b1);
          end
        end
        OP_POP: begin
          if (cnt > list_len) rejected = 1'b1;
          else take_run(list_len - cnt, cnt);
        end
        OP_INSERT: begin
          if (list_len + 1 > cap || idx > list_len) begin
            rejected = 1'b1;
          end else begin
            for (int unsigned i = list_len; i > idx; i--) begin
              cells[i] = cells[i - 1];
            end
            cells[idx] = req.value;
            list_len++;
            expect_result('0, STATUS_OK, 1'b1);
          end
        end
        default: begin
          if (idx + cnt > list_len) rejected = 1'b1;
          else take_run(idx, cnt);
        end
      endcase
      if (rejected) expect_result('0, STATUS_REJECT, 1'b1);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bal_out_t exp_r;
    if (!rst_ni) begin
      list_len  = 0;
      limit_reg = LIMIT_RST;
      pending_results.delete();
      err_cnt   = 0;
    end else begin
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      if (req_valid_i && req_ready_i) apply_request(req_data_i);
      if (res_valid_i && res_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: data_out %h status %b last %b",
                 res_data_i.data_out, res_data_i.status, res_data_i.last);
          err_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          if (res_data_i.data_out !== exp_r.data_out) begin
            $error("data_out: expected %h, actual %h", exp_r.data_out, res_data_i.data_out);
            err_cnt++;
          end
          if (res_data_i.status !== exp_r.status) begin
            $error("status: expected %b, actual %b", exp_r.status, res_data_i.status);
            err_cnt++;
          end
          if (res_data_i.last !== exp_r.last) begin
            $error("last: expected %b, actual %b", exp_r.last, res_data_i.last);
            err_cnt++;
          end
        end
      end
    end
    err_cnt_o  <= err_cnt;
    pending_o  <= pending_results.size();
    list_len_o <= list_len;
  end

endmodule

[tb/sv/tb_bounded_array_list.sv]
`timescale 1ns / 100ps

module tb_bounded_array_list;
  import bal_pkg::*;

  localparam int unsigned MAX_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  int unsigned        err_cnt;
  int unsigned        pending;
  int unsigned        list_len;
  int unsigned        cycles;
  bit                 tx_burst;
  bit                 rx_burst;
  int unsigned        hold_reqs;

  bal_stream_if #(.T(bal_in_t))  req_ch ();
  bal_stream_if #(.T(bal_out_t)) res_ch ();

  bounded_array_list DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (req_ch),
    .out_if      (res_ch)
  );

  bal_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_data_i  (req_ch.data),
    .res_valid_i (res_ch.valid),
    .res_ready_i (res_ch.ready),
    .res_data_i  (res_ch.data),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .list_len_o  (list_len)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: pick_value = '0;
      1: pick_value = '1;
      default: pick_value = $urandom;
    endcase
  endfunction

  task automatic offer_request(op_e op, int unsigned idx, int unsigned cnt,
                               logic [VAL_W-1:0] val);
    int unsigned gap;
    if ($urandom_range(0, 24) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_ch.valid      <= 1'b1;
    req_ch.data.op    <= op;
    req_ch.data.index <= idx[IDX_W-1:0];
    req_ch.data.count <= cnt[CNT_W-1:0];
    req_ch.data.value <= val;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // sender pauses until every expected result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // mostly legal requests shaped by the current length, some raw noise
  task automatic random_request();
    int unsigned sel;
    int unsigned len;
    int unsigned idx;
    len = list_len;
    sel = $urandom_range(0, 99);
    if ((sel >= 30 && sel < 65 || sel >= 65 && sel < 80) && len == 0) sel = 0;
    if (sel < 30) begin
      offer_request(OP_PUSH, $urandom_range(0, 31),
                    ($urandom_range(0, 5) == 0) ? $urandom_range(2, 31) : 1, pick_value());
    end else if (sel < 45) begin
      offer_request(OP_POP, $urandom_range(0, 31), $urandom_range(1, len), pick_value());
    end else if (sel < 65) begin
      idx = $urandom_range(0, len - 1);
      offer_request(OP_REMOVE, idx, $urandom_range(1, len - idx), pick_value());
    end else if (sel < 80) begin
      offer_request(OP_INSERT, $urandom_range(0, len), 1, pick_value());
    end else begin
      offer_request(op_e'($urandom_range(0, 3)), $urandom_range(0, 31),
                    $urandom_range(0, 31), pick_value());
    end
  endtask

  initial begin
    int unsigned stall;
    int unsigned holds_done;
    holds_done   = 0;
    res_ch.ready = 1'b0;
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        @(negedge clk_i);
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if ($urandom_range(0, 24) == 0) rx_burst = ~rx_burst;
        stall = rx_burst ? 0 : $urandom_range(0, 13);
        repeat (stall) begin
          @(negedge clk_i);
          res_ch.ready <= 1'b0;
        end
      end
      @(negedge clk_i);
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
    end
  end

  initial begin
    logic [LIMIT_W-1:0] phase_limits [8];
    phase_limits = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd5, 5'd16, 5'd12, 5'd16};
    phase_limits[6] = LIMIT_W'($urandom_range(0, 31));
    tx_burst     = 1'b0;
    hold_reqs    = 0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst_ni       = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    offer_request(OP_PUSH, 0, 0, 32'h1234_5678);
    offer_request(OP_POP, 0, 1, '0);
    offer_request(OP_REMOVE, 0, 1, '0);
    offer_request(OP_INSERT, 1, 1, 32'h0bad_0001);
    offer_request(OP_PUSH, 31, 1, 32'hFFFF_FFFF);
    offer_request(OP_PUSH, 0, 31, 32'h0000_0000);
    offer_request(OP_INSERT, 0, 1, 32'hA5A5_A5A5);
    offer_request(OP_INSERT, 3, 1, 32'h5A5A_5A5A);
    offer_request(OP_INSERT, 31, 1, 32'hDEAD_BEEF);
    offer_request(OP_REMOVE, 1, 2, '1);
    offer_request(OP_POP, 0, 31, '0);
    set_limit(5'd3);
    offer_request(OP_PUSH, 0, 1, 32'h0000_0003);
    offer_request(OP_PUSH, 0, 1, 32'h0000_0004);
    offer_request(OP_INSERT, 0, 1, 32'h0000_0005);
    set_limit(5'd1);
    offer_request(OP_PUSH, 0, 1, 32'h0000_0006);
    offer_request(OP_POP, 0, 1, '0);
    offer_request(OP_POP, 0, 2, '0);
    set_limit(5'd0);
    offer_request(OP_PUSH, 0, 1, 32'h0000_0007);
    offer_request(OP_INSERT, 0, 1, 32'h0000_0008);
    set_limit(5'd31);
    offer_request(OP_PUSH, 0, 1, 32'h8000_0000);
    offer_request(OP_PUSH, 0, 1, 32'h7FFF_FFFF);
    offer_request(OP_REMOVE, 1, 2, '0);
    offer_request(OP_REMOVE, 0, 2, '0);

    foreach (phase_limits[p]) begin
      set_limit(phase_limits[p]);
      repeat (52) random_request();
      if (p == 1) begin
        // receiver holds off while the sender keeps offering requests
        wait_drained();
        hold_reqs++;
        for (int i = 0; i < 20; i++) begin
          if (i % 3 == 2) offer_request(OP_POP, 0, 2, '0);
          else offer_request(OP_PUSH, 0, 1, $urandom);
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
